// ===== hdl/hysteresis_peak_valley_detector_defines.svh =====
// Assertion macros for the hysteresis peak/valley detector.
`ifndef HYSTERESIS_PEAK_VALLEY_DETECTOR_DEFINES_SVH
`define HYSTERESIS_PEAK_VALLEY_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HPVD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HPVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hpvd_pkg.sv =====
// Types and constants for the hysteresis peak/valley detector.
package hpvd_pkg;

  localparam int MaxLenDefault = 256;
  localparam int QueueDepth    = 4;
  localparam int SampleW       = 13;
  localparam int ValueW        = 15;
  localparam int ThrW          = 13;
  localparam int OutPosW       = 8;
  localparam int CountW        = 9;
  localparam int DataW         = 32;
  localparam int AddrW         = 3;

  localparam logic signed [ValueW-1:0] SentinelHigh = 15'sd10000;
  localparam logic signed [ValueW-1:0] SentinelLow  = -15'sd10000;
  localparam logic [ThrW-1:0]          ThrReset     = 13'd2;
  localparam logic [CountW-1:0]        SeenMax      = 9'd511;

  // Word index of the single configuration register (paddr bit 2)
  localparam logic RegSwingThreshold = 1'b0;

  localparam logic KindExtremum = 1'b0;
  localparam logic KindCount    = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic                      is_peak;
    logic [OutPosW-1:0]        position;
    logic signed [ValueW-1:0]  value;
    logic [CountW-1:0]         count;
    logic                      last;
  } res_t;

endpackage

// ===== hdl/hysteresis_peak_valley_detector.sv =====
// Hysteresis peak/valley detector: input register, tracker update, result queue.
// A request is registered on acceptance; once the queue has room, its results are computed
// from the input register and written into the queue, from whose head they are output.
// Throughput: one sample per cycle; a final sample yields up to three results,
// drained one per cycle unless the output stalls; a held request stalls while the 4-entry queue lacks 3 free slots.
// Reset clears the tracker, sample counter and queue; swing threshold resets to 2.
`include "hysteresis_peak_valley_detector_defines.svh"

module hysteresis_peak_valley_detector #(
  parameter int MAX_LEN = hpvd_pkg::MaxLenDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // sample channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [hpvd_pkg::SampleW-1:0]   sample_i,
  input  logic                                  is_last_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  result_kind_o,
  output logic                                  is_peak_o,
  output logic [hpvd_pkg::OutPosW-1:0]          position_o,
  output logic signed [hpvd_pkg::ValueW-1:0]    extreme_value_o,
  output logic [hpvd_pkg::CountW-1:0]           extremum_count_o,
  output logic                                  last_result_o,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [hpvd_pkg::AddrW-1:0]            paddr,
  input  logic [hpvd_pkg::DataW-1:0]            pwdata,
  output logic [hpvd_pkg::DataW-1:0]            prdata,
  output logic                                  pready
);
  import hpvd_pkg::*;

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int SAT_W = (POS_W > OutPosW) ? POS_W : OutPosW;
  localparam int PTR_W = $clog2(QueueDepth);
  localparam int CNT_W = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic                     seek_peak;
    logic signed [ValueW-1:0] cand_val;
    logic [POS_W-1:0]         cand_pos;
    logic [CountW-1:0]        seen;
    logic                     have;
  } trk_t;

  typedef struct packed {
    trk_t trk;
    logic emit;
    res_t res;
  } step_t;

  function automatic logic [OutPosW-1:0] sat_pos(logic [POS_W-1:0] p);
    logic [SAT_W-1:0] ext;
    ext = SAT_W'(p);
    return (ext > SAT_W'(255)) ? {OutPosW{1'b1}} : ext[OutPosW-1:0];
  endfunction

  // One value against the running candidate
  function automatic step_t apply_val(trk_t t, logic signed [ValueW-1:0] v,
                                      logic [POS_W-1:0] p, logic [ThrW-1:0] thr);
    step_t              s;
    logic signed [15:0] diff;
    logic signed [15:0] thr_s;
    logic               conf;
    logic               more;
    s      = '0;
    s.trk  = t;
    thr_s  = {3'b000, thr};
    diff   = t.seek_peak ? ({t.cand_val[ValueW-1], t.cand_val} - {v[ValueW-1], v})
                         : ({v[ValueW-1], v} - {t.cand_val[ValueW-1], t.cand_val});
    conf   = t.have && (diff >= thr_s);
    more   = t.seek_peak ? (v > t.cand_val) : (v < t.cand_val);
    s.res.kind     = KindExtremum;
    s.res.is_peak  = t.seek_peak;
    s.res.position = sat_pos(t.cand_pos);
    s.res.value    = t.cand_val;
    if (!t.have) begin
      s.trk.cand_val = v;
      s.trk.cand_pos = p;
      s.trk.have     = 1'b1;
    end else if (conf) begin
      s.emit          = 1'b1;
      s.trk.seen      = (t.seen < SeenMax) ? t.seen + 9'd1 : t.seen;
      s.trk.seek_peak = !t.seek_peak;
      s.trk.cand_val  = v;
      s.trk.cand_pos  = p;
    end else if (more) begin
      s.trk.cand_val = v;
      s.trk.cand_pos = p;
    end
    return s;
  endfunction

  // configuration register
  logic [ThrW-1:0] thr_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegSwingThreshold);
  assign prdata = (paddr[2] == RegSwingThreshold) ? DataW'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_wr) begin
      thr_q <= pwdata[ThrW-1:0];
    end
  end

  // input register
  logic                      in_valid_q;
  logic signed [SampleW-1:0] sample_q;
  logic                      last_q;
  logic                      room;
  logic                      proc;
  logic                      load;
  logic [CNT_W-1:0]          cnt_q;
  logic [CNT_W-1:0]          cnt_d;

  assign room       = (cnt_q <= CNT_W'(QueueDepth - 3));
  assign proc       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= sample_i;
      last_q   <= is_last_i;
    end
  end

  // tracker update
  trk_t                     trk_q;
  trk_t                     trk_d;
  logic [POS_W-1:0]         pos_q;
  logic [POS_W-1:0]         pos_d;
  logic [POS_W-1:0]         nxt_pos;
  logic signed [ValueW-1:0] av;
  step_t                    st1;
  step_t                    st2;
  res_t                     cres;
  res_t                     rlist [3];
  logic [2:0]               rvld;
  res_t                     ord [3];
  logic [1:0]               n_push;

  assign nxt_pos = (pos_q < POS_W'(MAX_LEN)) ? pos_q + POS_W'(1) : pos_q;
  // final sample is replaced by the high sentinel
  assign av      = last_q ? SentinelHigh : {{(ValueW-SampleW){sample_q[SampleW-1]}}, sample_q};
  assign st1     = apply_val(trk_q, av, pos_q, thr_q);
  assign st2     = apply_val(st1.trk, SentinelLow, nxt_pos, thr_q);

  always_comb begin
    cres          = '0;
    cres.kind     = KindCount;
    cres.last     = 1'b1;
    cres.count    = trk_q.have ? {st2.trk.seen[CountW-1:1], 1'b0} : '0;
    rlist[0]      = st1.res;
    rlist[1]      = st2.res;
    rlist[2]      = cres;
    rvld[0]       = st1.emit;
    rvld[1]       = last_q && trk_q.have && st2.emit;
    rvld[2]       = last_q;
  end

  // pack the pending results in order
  always_comb begin
    n_push = 2'd0;
    for (int k = 0; k < 3; k++) begin
      ord[k] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      if (rvld[k]) begin
        ord[n_push] = rlist[k];
        n_push      = n_push + 2'd1;
      end
    end
  end

  always_comb begin
    trk_d = trk_q;
    pos_d = pos_q;
    if (proc) begin
      if (last_q) begin
        trk_d = '0;
        pos_d = '0;
      end else begin
        trk_d = st1.trk;
        pos_d = nxt_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q <= '0;
      pos_q <= '0;
    end else begin
      trk_q <= trk_d;
      pos_q <= pos_d;
    end
  end

  // result queue
  res_t             qmem [QueueDepth];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic             pop;
  logic [1:0]       n_in;
  res_t             head;

  assign n_in        = proc ? n_push : 2'd0;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign cnt_d       = cnt_q + CNT_W'(n_in) - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < n_in) begin
        qmem[wr_ptr_q + PTR_W'(k)] <= ord[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(n_in);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      cnt_q    <= cnt_d;
    end
  end

  assign head             = qmem[rd_ptr_q];
  assign result_kind_o    = head.kind;
  assign is_peak_o        = head.is_peak;
  assign position_o       = head.position;
  assign extreme_value_o  = head.value;
  assign extremum_count_o = head.count;
  assign last_result_o    = head.last;

  `HPVD_ASSERT_NOW(a_queue_bound, 1'b1, cnt_q <= CNT_W'(QueueDepth), "result queue overflow")
  `HPVD_ASSERT_NOW(a_one_per_sample, proc && !last_q, n_push <= 2'd1, "ordinary sample gave two results")
  `HPVD_ASSERT_NEXT(a_end_clears, proc && last_q, !trk_q.have && (trk_q.seen == '0) && (pos_q == '0), "tracker not cleared after final sample")
  `HPVD_ASSERT_NOW(a_last_is_count, out_valid_o && last_result_o, result_kind_o && !is_peak_o, "final result is not a count")

endmodule
